FILE: design/ids2x_pkg.sv
// package: shared types and constants for the 2x2 box downscaler
`timescale 1ns / 1ps

package ids2x_pkg;

  localparam int DEF_MAX_WIDTH   = 4096;
  localparam int DEF_MAX_HEIGHT  = 4096;
  localparam int DEF_SAMPLE_BITS = 16;

  localparam int CFG_DATA_W = 13;
  localparam logic [CFG_DATA_W-1:0] RST_IMAGE_WIDTH  = 13'd640;
  localparam logic [CFG_DATA_W-1:0] RST_IMAGE_HEIGHT = 13'd480;

  typedef enum logic [0:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [15:0] red_in;
    logic [15:0] green_in;
    logic [15:0] blue_in;
  } pixel_in_t;

  typedef struct packed {
    logic [15:0] red_out;
    logic [15:0] green_out;
    logic [15:0] blue_out;
    logic        row_end;
    logic        frame_end;
  } pixel_out_t;

endpackage

FILE: design/image_downscale_2x_box_average_unit.sv
// top level: 2x2 box-average downscaler with a line store of pair sums
//
// Input pixels arrive in raster order on in_valid/in_ready/in_data. Every
// odd-column pixel of an odd row (within the even-trimmed image) yields one
// result on out_valid/out_ready/out_data: the rounded mean of its 2x2 block,
// with row_end and frame_end flags. Other pixels yield nothing.
// Image size comes from cfg_we/cfg_index/cfg_wdata; write only while idle.
// One request is taken per clock while out_ready is high. The line store
// is a single-port-write, one-read synchronous memory: an even-row pair
// sum is written at the accepting edge, an odd-row pixel reads its entry
// at that edge, and the sum is finished from the registered read data.
// A result passes the memory read stage, then the output register.
// Throughput: 1 pixel per clock while out_ready is high.
// When the receiver stalls, the output register holds its result and one
// more result waits at the memory read stage; in_ready falls only once
// both are full. Reset (rst_n low, synchronous) clears the counters,
// held pixel, pipeline flags and sets the size to 640 x 480. The line
// store is not cleared: every entry is written on an even row before the
// odd row below reads it.
`timescale 1ns / 1ps

module image_downscale_2x_box_average_unit #(
  parameter int MAX_WIDTH   = ids2x_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT  = ids2x_pkg::DEF_MAX_HEIGHT,
  parameter int SAMPLE_BITS = ids2x_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  ids2x_pkg::pixel_in_t                  in_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output ids2x_pkg::pixel_out_t                 out_data,
  input  logic                                  cfg_we,
  input  ids2x_pkg::cfg_index_t                 cfg_index,
  input  logic [ids2x_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  import ids2x_pkg::*;

  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int IDX_W      = $clog2(LINE_DEPTH);
  localparam int CNT_W      = $clog2(MAX_WIDTH);
  localparam int RCNT_W     = $clog2(MAX_HEIGHT);
  localparam int DW_W       = $clog2(MAX_WIDTH + 1);
  localparam int DH_W       = $clog2(MAX_HEIGHT + 1);
  localparam int CW_W       = (DW_W > CFG_DATA_W) ? DW_W : CFG_DATA_W;
  localparam int CH_W       = (DH_W > CFG_DATA_W) ? DH_W : CFG_DATA_W;
  localparam int PAIR_W     = SAMPLE_BITS + 1;
  localparam int SUM_W      = SAMPLE_BITS + 2;
  localparam int LINE_W     = 3 * PAIR_W;

  // configuration
  logic [CFG_DATA_W-1:0] img_width_r, img_height_r;
  logic [DW_W-1:0]       w_use, w_even;
  logic [DH_W-1:0]       h_use, h_even;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_width_r  <= RST_IMAGE_WIDTH;
      img_height_r <= RST_IMAGE_HEIGHT;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  img_width_r  <= cfg_wdata;
        CFG_IMAGE_HEIGHT: img_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (img_width_r < CFG_DATA_W'(2)) begin
      w_use = DW_W'(2);
    end else if (CW_W'(img_width_r) > CW_W'(MAX_WIDTH)) begin
      w_use = DW_W'(MAX_WIDTH);
    end else begin
      w_use = DW_W'(img_width_r);
    end
    if (img_height_r < CFG_DATA_W'(2)) begin
      h_use = DH_W'(2);
    end else if (CH_W'(img_height_r) > CH_W'(MAX_HEIGHT)) begin
      h_use = DH_W'(MAX_HEIGHT);
    end else begin
      h_use = DH_W'(img_height_r);
    end
    w_even = {w_use[DW_W-1:1], 1'b0};
    h_even = {h_use[DH_W-1:1], 1'b0};
  end

  // position and held pixel
  logic [CNT_W-1:0]       col_r, col_nxt;
  logic [RCNT_W-1:0]      row_r, row_nxt;
  logic [SAMPLE_BITS-1:0] held_r_r, held_g_r, held_b_r;
  logic [SAMPLE_BITS-1:0] px_r, px_g, px_b;
  logic [PAIR_W-1:0]      pair_r, pair_g, pair_b;
  logic [IDX_W-1:0]       line_idx;
  logic                   accept, in_block, wr_en, rd_en, last_col, last_row;
  logic                   col_wrap, row_wrap;

  // pipeline control
  logic              s1_valid_r, s1_valid_nxt;
  logic [LINE_W-1:0] s1_pair_r;
  logic              s1_row_end_r, s1_frame_end_r;
  logic              s1_move;
  logic              out_valid_r, out_valid_nxt;
  pixel_out_t        out_data_r;
  logic [LINE_W-1:0] rd_data_r;
  logic [LINE_W-1:0] line_mem [LINE_DEPTH];

  assign s1_move  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_move;
  assign accept   = in_valid && in_ready;

  assign px_r = in_data.red_in[SAMPLE_BITS-1:0];
  assign px_g = in_data.green_in[SAMPLE_BITS-1:0];
  assign px_b = in_data.blue_in[SAMPLE_BITS-1:0];

  assign pair_r = PAIR_W'(held_r_r) + PAIR_W'(px_r);
  assign pair_g = PAIR_W'(held_g_r) + PAIR_W'(px_g);
  assign pair_b = PAIR_W'(held_b_r) + PAIR_W'(px_b);

  assign line_idx = IDX_W'(col_r >> 1);
  assign in_block = col_r[0] && (DW_W'(col_r) < w_even) && (DH_W'(row_r) < h_even);
  assign wr_en    = accept && in_block && !row_r[0];
  assign rd_en    = accept && in_block && row_r[0];
  assign last_col = (DW_W'(col_r) + DW_W'(1)) == w_even;
  assign last_row = (DH_W'(row_r) + DH_W'(1)) == h_even;
  assign col_wrap = (DW_W'(col_r) + DW_W'(1)) >= w_use;
  assign row_wrap = (DH_W'(row_r) + DH_W'(1)) >= h_use;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (col_wrap) begin
        col_nxt = '0;
        row_nxt = row_wrap ? '0 : row_r + RCNT_W'(1);
      end else begin
        col_nxt = col_r + CNT_W'(1);
      end
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end
    if (rd_en) begin
      s1_valid_nxt = 1'b1;
    end
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (s1_move) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      held_r_r    <= '0;
      held_g_r    <= '0;
      held_b_r    <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (accept && !col_r[0]) begin
        held_r_r <= px_r;
        held_g_r <= px_g;
        held_b_r <= px_b;
      end
    end
  end

  // line store of even-row pair sums
  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_mem[line_idx] <= {pair_r, pair_g, pair_b};
    end
    if (rd_en) begin
      rd_data_r <= line_mem[line_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_pair_r      <= {pair_r, pair_g, pair_b};
      s1_row_end_r   <= last_col;
      s1_frame_end_r <= last_col && last_row;
    end
  end

  // block sum and rounding
  logic [SUM_W-1:0] sum_r, sum_g, sum_b;

  assign sum_r = SUM_W'(rd_data_r[3*PAIR_W-1:2*PAIR_W]) +
                 SUM_W'(s1_pair_r[3*PAIR_W-1:2*PAIR_W]) + SUM_W'(2);
  assign sum_g = SUM_W'(rd_data_r[2*PAIR_W-1:PAIR_W]) +
                 SUM_W'(s1_pair_r[2*PAIR_W-1:PAIR_W]) + SUM_W'(2);
  assign sum_b = SUM_W'(rd_data_r[PAIR_W-1:0]) +
                 SUM_W'(s1_pair_r[PAIR_W-1:0]) + SUM_W'(2);

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_data_r.red_out   <= 16'(sum_r[SUM_W-1:2]);
      out_data_r.green_out <= 16'(sum_g[SUM_W-1:2]);
      out_data_r.blue_out  <= 16'(sum_b[SUM_W-1:2]);
      out_data_r.row_end   <= s1_row_end_r;
      out_data_r.frame_end <= s1_frame_end_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: design/ids2x_checker.sv
// checker: port-level assertions for the downscaler, bound to the top level
`timescale 1ns / 1ps

module ids2x_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input ids2x_pkg::pixel_out_t out_data
);

  import ids2x_pkg::*;

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // an empty output register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("in_ready low with empty output");

  // end of frame is always end of a row
  a_frame_end_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.frame_end |-> out_data.row_end)
    else $error("frame_end without row_end");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind image_downscale_2x_box_average_unit ids2x_checker u_ids2x_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

FILE: tb/sv/image_downscale_2x_box_average_checker.sv
// checker: predicts each 2x2 block mean from accepted pixels and compares the output stream
`timescale 1ns / 1ps

module image_downscale_2x_box_average_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  ids2x_pkg::pixel_in_t             in_data,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  ids2x_pkg::pixel_out_t            out_data,
  input  logic                             cfg_we,
  input  ids2x_pkg::cfg_index_t            cfg_index,
  input  logic [ids2x_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                               fail_count,
  output int                               pending_count
);

  import ids2x_pkg::*;

  localparam int LINE_DEPTH = DEF_MAX_WIDTH / 2;

  logic [CFG_DATA_W-1:0] width_reg;
  logic [CFG_DATA_W-1:0] height_reg;
  logic [16:0]           pair_red   [LINE_DEPTH];
  logic [16:0]           pair_green [LINE_DEPTH];
  logic [16:0]           pair_blue  [LINE_DEPTH];
  pixel_in_t             held_pixel;
  logic [11:0]           col_count;
  logic [11:0]           row_count;
  pixel_out_t            block_means_q[$];

  function automatic int span(input logic [CFG_DATA_W-1:0] v, input int hi);
    if (v < 2) return 2;
    if (v > hi) return hi;
    return int'(v);
  endfunction

  function automatic void take_pixel(input pixel_in_t px);
    int          w;
    int          h;
    int          w_even;
    int          h_even;
    int          c;
    int          r;
    int          idx;
    logic [16:0] pr;
    logic [16:0] pg;
    logic [16:0] pb;
    logic [18:0] sr;
    logic [18:0] sg;
    logic [18:0] sb;
    pixel_out_t  mean;
    w      = span(width_reg, DEF_MAX_WIDTH);
    h      = span(height_reg, DEF_MAX_HEIGHT);
    w_even = w & ~1;
    h_even = h & ~1;
    c      = int'(col_count);
    r      = int'(row_count);
    if (c % 2 == 0) begin
      held_pixel = px;
    end else if (c < w_even && r < h_even) begin
      idx = (c >> 1) % LINE_DEPTH;
      pr  = {1'b0, held_pixel.red_in}   + {1'b0, px.red_in};
      pg  = {1'b0, held_pixel.green_in} + {1'b0, px.green_in};
      pb  = {1'b0, held_pixel.blue_in}  + {1'b0, px.blue_in};
      if (r % 2 == 0) begin
        pair_red[idx]   = pr;
        pair_green[idx] = pg;
        pair_blue[idx]  = pb;
      end else begin
        sr = {2'b00, pair_red[idx]}   + {2'b00, pr} + 19'd2;
        sg = {2'b00, pair_green[idx]} + {2'b00, pg} + 19'd2;
        sb = {2'b00, pair_blue[idx]}  + {2'b00, pb} + 19'd2;
        mean.red_out   = sr[17:2];
        mean.green_out = sg[17:2];
        mean.blue_out  = sb[17:2];
        mean.row_end   = (c + 1 == w_even);
        mean.frame_end = (c + 1 == w_even) && (r + 1 == h_even);
        block_means_q.push_back(mean);
      end
    end
    if (c + 1 >= w) begin
      col_count = '0;
      row_count = (r + 1 >= h) ? '0 : 12'(r + 1);
    end else begin
      col_count = 12'(c + 1);
    end
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    pixel_out_t want;
    if (!rst_n) begin
      width_reg  = RST_IMAGE_WIDTH;
      height_reg = RST_IMAGE_HEIGHT;
      held_pixel = '0;
      col_count  = '0;
      row_count  = '0;
      block_means_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_IMAGE_WIDTH:  width_reg  = cfg_wdata;
          CFG_IMAGE_HEIGHT: height_reg = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        take_pixel(in_data);
      end
      if (out_valid && out_ready) begin
        if (block_means_q.size() == 0) begin
          $error("unexpected result %p with no block mean pending", out_data);
          fail_count++;
        end else begin
          want = block_means_q.pop_front();
          check_field("red_out", int'(want.red_out), int'(out_data.red_out));
          check_field("green_out", int'(want.green_out), int'(out_data.green_out));
          check_field("blue_out", int'(want.blue_out), int'(out_data.blue_out));
          check_field("row_end", int'(want.row_end), int'(out_data.row_end));
          check_field("frame_end", int'(want.frame_end), int'(out_data.frame_end));
        end
      end
    end
    pending_count <= block_means_q.size();
  end

endmodule

FILE: tb/sv/image_downscale_2x_box_average_unit_tb.sv
// testbench top: drives pixel frames and size settings into the 2x2 downscaler
`timescale 1ns / 1ps

module image_downscale_2x_box_average_unit_tb;
  import ids2x_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;

  typedef enum int {
    PAT_BOX_CASES,
    PAT_RANDOM,
    PAT_EXTREME,
    PAT_LOW
  } pattern_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  pixel_in_t             in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  pixel_out_t            out_data;
  logic                  cfg_we    = 1'b0;
  cfg_index_t            cfg_index = CFG_IMAGE_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  int                    fail_count;
  int                    pending_count;
  int                    cycle_count = 0;
  int                    pixels_sent = 0;
  bit                    steady_send = 1'b0;
  bit                    steady_take = 1'b0;

  image_downscale_2x_box_average_unit i_dut (.*);

  image_downscale_2x_box_average_checker i_checker (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 8);
    return $urandom_range(12, 24);
  endfunction

  function automatic int clamped_size(input logic [CFG_DATA_W-1:0] v, input int hi);
    if (v < 2) return 2;
    if (v > hi) return hi;
    return int'(v);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_dim(input int common_max);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) return CFG_DATA_W'($urandom_range(0, 1));
    if (roll < 75) return CFG_DATA_W'($urandom_range(2, common_max));
    return CFG_DATA_W'($urandom_range(common_max + 1, 40));
  endfunction

  function automatic pixel_in_t make_pixel(input pattern_t pat, input int r, input int c);
    pixel_in_t px;
    int        rr;
    int        cc;
    rr = r % 2;
    cc = c % 2;
    px = 48'({$urandom, $urandom});
    case (pat)
      PAT_BOX_CASES: begin
        case ((r / 2) * 2 + c / 2)
          0: px = {16'hFFFF, 16'hFFFF, 16'hFFFF};
          1: px = '0;
          2: begin
            px.red_in   = (rr && cc) ? 16'd1 : 16'd0;
            px.green_in = rr ? 16'd1 : 16'd0;
            px.blue_in  = (rr || cc) ? 16'd1 : 16'd0;
          end
          default: begin
            px.red_in   = cc ? 16'h0000 : 16'hFFFF;
            px.green_in = rr ? 16'hFFFF : 16'h0000;
            px.blue_in  = (rr != cc) ? 16'hAAAA : 16'h5555;
          end
        endcase
      end
      PAT_EXTREME: begin
        px.red_in   = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        px.green_in = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        px.blue_in  = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      end
      PAT_LOW: begin
        px.red_in   = 16'($urandom_range(0, 3));
        px.green_in = 16'($urandom_range(0, 3));
        px.blue_in  = 16'($urandom_range(0, 3));
      end
      default: ;
    endcase
    return px;
  endfunction

  task automatic send_pixel(input pixel_in_t px);
    int gap;
    gap = steady_send ? 0 : pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= px;
    do @(posedge clk); while (!in_ready);
    pixels_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic resize(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
    drain();
    // requests in dropped rows or columns may still be in flight
    repeat (4) @(negedge clk);
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
  endtask

  task automatic send_frame(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
                            input pattern_t pat);
    int cols;
    int rows;
    cols = clamped_size(w, DEF_MAX_WIDTH);
    rows = clamped_size(h, DEF_MAX_HEIGHT);
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c < cols; c++) begin
        if (pixels_sent == 300 || $urandom_range(0, 499) == 0) drain();
        send_pixel(make_pixel(pat, r, c));
      end
    end
  endtask

  initial begin
    int         take_stall;
    int         take_run;
    take_stall = 0;
    take_run   = 0;
    forever begin
      if ($urandom_range(0, 19) == 0) steady_take = !steady_take;
      take_stall = steady_take ? 0 : pick_gap();
      repeat (take_stall) begin
        @(negedge clk);
        out_ready <= 1'b0;
      end
      take_run = $urandom_range(1, 12);
      repeat (take_run) begin
        @(negedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    logic [CFG_DATA_W-1:0] w;
    logic [CFG_DATA_W-1:0] h;
    int                    frames;
    pattern_t              pat;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_reg(CFG_IMAGE_WIDTH, 13'd4);
    write_reg(CFG_IMAGE_HEIGHT, 13'd4);
    send_frame(13'd4, 13'd4, PAT_BOX_CASES);
    resize(13'd3, 13'd3);
    send_frame(13'd3, 13'd3, PAT_EXTREME);

    while (pixels_sent < 1150) begin
      w = pick_dim(12);
      h = pick_dim(8);
      resize(w, h);
      steady_send = ($urandom_range(0, 3) == 0);
      frames = $urandom_range(1, 3);
      case ($urandom_range(0, 9))
        0, 1:    pat = PAT_EXTREME;
        2:       pat = PAT_LOW;
        default: pat = PAT_RANDOM;
      endcase
      repeat (frames) send_frame(w, h, pat);
    end

    steady_send = 1'b0;
    resize(13'd1, 13'd0);
    send_frame(13'd1, 13'd0, PAT_RANDOM);

    drain();
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/ids2x_pkg.sv
design/image_downscale_2x_box_average_unit.sv
design/ids2x_checker.sv
tb/sv/image_downscale_2x_box_average_checker.sv
tb/sv/image_downscale_2x_box_average_unit_tb.sv
